FILE: rtl/tdcrp_pkg.sv
// ----------------------------------------------------------------------------
// TDC readout packet parser package
// Shared types and constants for the readout word deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package tdcrp_pkg;

	// Default limit on words stored per packet, header included.
	localparam int MAX_WORDS_DEF = 64;

	// Enabled channel after reset: channel 24.
	localparam logic [4:0] CHAN_RESET = 5'd24;

	// Depth of the queue between the front and the back part.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// Result kinds.
	localparam logic KIND_HIT     = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Summary status codes.
	localparam logic [1:0] STATUS_HITS  = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_SHORT = 2'd2;

	// Bit positions in check_flags.
	localparam int CHK_BAD_HEADER = 0;
	localparam int CHK_COUNT      = 1;
	localparam int CHK_EVENT      = 2;
	localparam int CHK_OVERFLOW   = 3;
	localparam int CHK_NON_MEAS   = 4;

	// Bit positions in the packet flags.
	localparam int PF_BAD_HEADER = 0;
	localparam int PF_OVERFLOW   = 1;
	localparam int PF_NON_MEAS   = 2;

	// Largest hit count a summary can report.
	localparam logic [6:0] HIT_COUNT_MAX = 7'd127;

	typedef enum logic [1:0] {
		CLS_ERROR   = 2'd0,
		CLS_TRAILER = 2'd1,
		CLS_DATA    = 2'd2
	} word_class_t;

	// One classified readout word as it travels through the queue.
	typedef struct packed {
		word_class_t cls;
		logic        is_meas;
		logic        hdr_ok;
		logic [31:0] word;
	} item_t;

endpackage

`default_nettype wire

FILE: rtl/tdcrp_front.sv
// ----------------------------------------------------------------------------
// TDC readout packet parser: front part
// Accepts readout words and sorts them into error, trailer and data words.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcrp_front (
	input  wire logic             in_valid,
	input  wire logic [31:0]      data_word,
	output logic                  in_stall,
	input  wire logic             q_full,
	output logic                  q_push,
	output tdcrp_pkg::item_t      q_item
);

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// The error test takes precedence over the trailer test.
	always_comb begin
		q_item.word    = data_word;
		q_item.is_meas = data_word[29] && data_word[28];
		q_item.hdr_ok  = data_word[31] && data_word[29];
		if (data_word[30] && data_word[29]) begin
			q_item.cls = tdcrp_pkg::CLS_ERROR;
		end else if (data_word[31] && data_word[30]) begin
			q_item.cls = tdcrp_pkg::CLS_TRAILER;
		end else begin
			q_item.cls = tdcrp_pkg::CLS_DATA;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tdcrp_queue.sv
// ----------------------------------------------------------------------------
// TDC readout packet parser: item queue
// Short queue of classified words between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcrp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire tdcrp_pkg::item_t push_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output tdcrp_pkg::item_t      head_item
);

	tdcrp_pkg::item_t                      mem_q [tdcrp_pkg::QUEUE_DEPTH];
	logic [tdcrp_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q;
	logic [tdcrp_pkg::QUEUE_PTR_W-1:0]     rd_ptr_q;
	logic [tdcrp_pkg::QUEUE_CNT_W-1:0]     count_q;

	assign full      = (count_q == tdcrp_pkg::QUEUE_CNT_W'(tdcrp_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tdcrp_back.sv
// ----------------------------------------------------------------------------
// TDC readout packet parser: back part
// Keeps the packet state, builds hit results and packet summaries, and
// holds them in the output register until they are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tdcrp_back #(
	parameter int MAX_WORDS = tdcrp_pkg::MAX_WORDS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [4:0]       enabled_channel,
	input  wire logic             q_not_empty,
	input  wire tdcrp_pkg::item_t q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  kind,
	output logic [4:0]            channel,
	output logic                  edge_res,
	output logic                  hit_error,
	output logic [16:0]           hit_time,
	output logic                  channel_mismatch,
	output logic [11:0]           event_id,
	output logic [11:0]           bunch_id,
	output logic [13:0]           error_flags,
	output logic [6:0]            hit_count,
	output logic [1:0]            status,
	output logic [4:0]            check_flags
);

	localparam int WC_W  = $clog2(MAX_WORDS + 1);
	localparam int HIT_W = (WC_W > 7) ? WC_W : 7;
	localparam int CMP_W = ((WC_W > 12) ? WC_W : 12) + 2;

	// Packet state.
	logic [WC_W-1:0] word_count_q,   word_count_d;
	logic [13:0]     err_acc_q,      err_acc_d;
	logic [11:0]     hdr_event_q,    hdr_event_d;
	logic [11:0]     hdr_bunch_q,    hdr_bunch_d;
	logic [2:0]      pkt_flags_q,    pkt_flags_d;

	// Output register.
	logic        out_valid_q;
	logic        kind_q,   kind_d;
	logic [4:0]  chan_q,   chan_d;
	logic        edge_q,   edge_d;
	logic        herr_q,   herr_d;
	logic [16:0] time_q,   time_d;
	logic        mism_q,   mism_d;
	logic [11:0] evt_q,    evt_d;
	logic [11:0] bcid_q,   bcid_d;
	logic [13:0] errf_q,   errf_d;
	logic [6:0]  hits_q,   hits_d;
	logic [1:0]  stat_q,   stat_d;
	logic [4:0]  chk_q,    chk_d;
	logic        load;

	logic             out_free;
	logic [HIT_W-1:0] hits_raw;
	logic [CMP_W-1:0] count_expect;
	logic             count_bad;
	logic             no_header;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = q_not_empty && out_free;

	assign no_header = (word_count_q == '0);
	assign hits_raw  = HIT_W'(word_count_q) - HIT_W'(1);

	// The trailer count is compared against the stored words plus one, plus
	// one more for each error group that saw an error.
	assign count_expect = CMP_W'(word_count_q) + CMP_W'(1)
		+ CMP_W'(|err_acc_q[13:9]) + CMP_W'(|err_acc_q[8:0]);
	assign count_bad = (CMP_W'(q_item.word[11:0]) != count_expect);

	always_comb begin
		word_count_d = word_count_q;
		err_acc_d    = err_acc_q;
		hdr_event_d  = hdr_event_q;
		hdr_bunch_d  = hdr_bunch_q;
		pkt_flags_d  = pkt_flags_q;
		load         = 1'b0;
		kind_d       = tdcrp_pkg::KIND_HIT;
		chan_d       = '0;
		edge_d       = 1'b0;
		herr_d       = 1'b0;
		time_d       = '0;
		mism_d       = 1'b0;
		evt_d        = hdr_event_q;
		bcid_d       = hdr_bunch_q;
		errf_d       = '0;
		hits_d       = '0;
		stat_d       = tdcrp_pkg::STATUS_HITS;
		chk_d        = '0;
		if (q_pop) begin
			case (q_item.cls)
				tdcrp_pkg::CLS_ERROR: begin
					err_acc_d = err_acc_q | q_item.word[13:0];
				end
				tdcrp_pkg::CLS_TRAILER: begin
					load   = 1'b1;
					kind_d = tdcrp_pkg::KIND_SUMMARY;
					errf_d = err_acc_q;
					if (no_header) begin
						stat_d = tdcrp_pkg::STATUS_SHORT;
					end else begin
						if (hits_raw > HIT_W'(tdcrp_pkg::HIT_COUNT_MAX)) begin
							hits_d = tdcrp_pkg::HIT_COUNT_MAX;
						end else begin
							hits_d = hits_raw[6:0];
						end
						stat_d = (hits_raw == '0) ? tdcrp_pkg::STATUS_EMPTY
							: tdcrp_pkg::STATUS_HITS;
					end
					chk_d[tdcrp_pkg::CHK_BAD_HEADER] = no_header
						|| pkt_flags_q[tdcrp_pkg::PF_BAD_HEADER];
					chk_d[tdcrp_pkg::CHK_COUNT]    = count_bad;
					chk_d[tdcrp_pkg::CHK_EVENT]    = !no_header
						&& (q_item.word[23:12] != hdr_event_q);
					chk_d[tdcrp_pkg::CHK_OVERFLOW] = pkt_flags_q[tdcrp_pkg::PF_OVERFLOW];
					chk_d[tdcrp_pkg::CHK_NON_MEAS] = pkt_flags_q[tdcrp_pkg::PF_NON_MEAS];
					word_count_d = '0;
					err_acc_d    = '0;
					hdr_event_d  = '0;
					hdr_bunch_d  = '0;
					pkt_flags_d  = '0;
				end
				tdcrp_pkg::CLS_DATA: begin
					if (word_count_q >= WC_W'(MAX_WORDS)) begin
						pkt_flags_d[tdcrp_pkg::PF_OVERFLOW] = 1'b1;
					end else if (no_header) begin
						hdr_event_d  = q_item.word[23:12];
						hdr_bunch_d  = q_item.word[11:0];
						word_count_d = WC_W'(1);
						if (!q_item.hdr_ok) begin
							pkt_flags_d[tdcrp_pkg::PF_BAD_HEADER] = 1'b1;
						end
					end else begin
						word_count_d = word_count_q + WC_W'(1);
						if (q_item.is_meas) begin
							load   = 1'b1;
							chan_d = q_item.word[23:19];
							edge_d = q_item.word[18];
							herr_d = q_item.word[17];
							time_d = q_item.word[16:0];
							mism_d = (q_item.word[23:19] != enabled_channel);
						end else begin
							pkt_flags_d[tdcrp_pkg::PF_NON_MEAS] = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
			err_acc_q    <= '0;
			hdr_event_q  <= '0;
			hdr_bunch_q  <= '0;
			pkt_flags_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			word_count_q <= word_count_d;
			err_acc_q    <= err_acc_d;
			hdr_event_q  <= hdr_event_d;
			hdr_bunch_q  <= hdr_bunch_d;
			pkt_flags_q  <= pkt_flags_d;
			if (out_free) begin
				out_valid_q <= load;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_d;
			chan_q <= chan_d;
			edge_q <= edge_d;
			herr_q <= herr_d;
			time_q <= time_d;
			mism_q <= mism_d;
			evt_q  <= evt_d;
			bcid_q <= bcid_d;
			errf_q <= errf_d;
			hits_q <= hits_d;
			stat_q <= stat_d;
			chk_q  <= chk_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = kind_q;
	assign channel          = chan_q;
	assign edge_res         = edge_q;
	assign hit_error        = herr_q;
	assign hit_time         = time_q;
	assign channel_mismatch = mism_q;
	assign event_id         = evt_q;
	assign bunch_id         = bcid_q;
	assign error_flags      = errf_q;
	assign hit_count        = hits_q;
	assign status           = stat_q;
	assign check_flags      = chk_q;

endmodule

`default_nettype wire

FILE: rtl/tdc_readout_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// TDC readout packet parser
// Deframes TDC readout words into hit results and packet summaries.
// ----------------------------------------------------------------------------
// One 32-bit readout word enters per beat on data_word (in_valid/in_stall).
// Header and non-measurement words and error words give no result; each
// measurement word after the header, within MAX_WORDS, gives one hit result,
// and each trailer gives one packet summary (out_valid/out_stall, kind
// selects which). Each accepted word is first written into the two-entry
// word queue and is then loaded into the output register once that register
// is free; the result is held there until it is taken.
// The block takes one word per cycle as long as the output is not stalled;
// the back part sets the rate: one queued word a cycle while its output is free.
// While out_stall holds a result, the back part waits and the queue fills;
// in_stall rises once both queue entries are occupied.
// enabled_channel is to be written via cfg_write/cfg_data only while idle;
// the user must see to that, as the block itself enforces nothing. Reset
// clears the packet state, empties the queue and drops any pending result;
// the enabled channel returns to 24. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module tdc_readout_packet_parser_unit #(
	parameter int MAX_WORDS = tdcrp_pkg::MAX_WORDS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] data_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [4:0]       channel,
	output logic             edge_res,
	output logic             hit_error,
	output logic [16:0]      hit_time,
	output logic             channel_mismatch,
	output logic [11:0]      event_id,
	output logic [11:0]      bunch_id,
	output logic [13:0]      error_flags,
	output logic [6:0]       hit_count,
	output logic [1:0]       status,
	output logic [4:0]       check_flags
);

	logic [4:0]       enabled_channel_q;
	logic             q_full;
	logic             q_push;
	logic             q_pop;
	logic             q_not_empty;
	tdcrp_pkg::item_t push_item;
	tdcrp_pkg::item_t head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_channel_q <= tdcrp_pkg::CHAN_RESET;
		end else if (cfg_write) begin
			enabled_channel_q <= cfg_data;
		end
	end

	tdcrp_front u_front (
		.in_valid  (in_valid),
		.data_word (data_word),
		.in_stall  (in_stall),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item)
	);

	tdcrp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_item (head_item)
	);

	tdcrp_back #(
		.MAX_WORDS (MAX_WORDS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.enabled_channel  (enabled_channel_q),
		.q_not_empty      (q_not_empty),
		.q_item           (head_item),
		.q_pop            (q_pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.channel          (channel),
		.edge_res         (edge_res),
		.hit_error        (hit_error),
		.hit_time         (hit_time),
		.channel_mismatch (channel_mismatch),
		.event_id         (event_id),
		.bunch_id         (bunch_id),
		.error_flags      (error_flags),
		.hit_count        (hit_count),
		.status           (status),
		.check_flags      (check_flags)
	);

endmodule

`default_nettype wire
